>>> hw/rtl/reb_pkg.sv
// Shared widths, constants, types and the arctangent table for the ellipse bounding box.
`default_nettype none
package reb_pkg;

    localparam int COORD_BITS      = 12;
    localparam int ANGLE_FRAC_BITS = 13;
    localparam int CORDIC_STEPS    = 16;
    localparam int ROT_BITS        = 15;
    localparam int ATAN_ENTRIES    = 24;

    localparam int ANG_W     = 34;
    localparam int XY_W      = 33;
    localparam int Q_SHIFT   = 30 - ANGLE_FRAC_BITS;
    localparam int TRIG_FRAC = 28 - COORD_BITS;
    localparam int XS_SHIFT  = 30 - TRIG_FRAC;
    localparam int XS_W      = TRIG_FRAC + 2;
    localparam int CC_W      = 2 * XS_W - 2;
    localparam int DEN_W     = CC_W + 1;
    localparam int SQ_W      = 2 * COORD_BITS;
    localparam int PROD_W    = SQ_W + CC_W;
    localparam int NUM_W     = PROD_W + 3;
    localparam int QUOT_W    = 2 * COORD_BITS + 2;
    localparam int ROOT_W    = COORD_BITS + 1;
    localparam int OUT_W     = COORD_BITS + 1;

    localparam logic signed [ANG_W-1:0] Q30_HALF_PI = 34'sd1686629713;
    localparam logic signed [ANG_W-1:0] Q30_PI      = 34'sd3373259426;
    localparam logic signed [XY_W-1:0]  Q30_ONE     = 33'sd1073741824;

    typedef struct packed {
        logic [OUT_W-1:0] left;
        logic [OUT_W-1:0] top;
        logic [OUT_W-1:0] width;
        logic [OUT_W-1:0] height;
    } t_box;

    function automatic logic [29:0] atan_q30(input logic [4:0] idx);
        logic [29:0] v;
        unique case (idx)
            5'd0:  v = 30'd843314856;
            5'd1:  v = 30'd497837829;
            5'd2:  v = 30'd263043836;
            5'd3:  v = 30'd133525158;
            5'd4:  v = 30'd67021686;
            5'd5:  v = 30'd33543515;
            5'd6:  v = 30'd16775850;
            5'd7:  v = 30'd8388437;
            5'd8:  v = 30'd4194282;
            5'd9:  v = 30'd2097149;
            5'd10: v = 30'd1048575;
            5'd11: v = 30'd524287;
            5'd12: v = 30'd262143;
            5'd13: v = 30'd131071;
            5'd14: v = 30'd65535;
            5'd15: v = 30'd32767;
            5'd16: v = 30'd16383;
            5'd17: v = 30'd8191;
            5'd18: v = 30'd4095;
            5'd19: v = 30'd2047;
            5'd20: v = 30'd1023;
            5'd21: v = 30'd511;
            5'd22: v = 30'd255;
            5'd23: v = 30'd127;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

>>> hw/rtl/reb_cordic.sv
// Angle reduction, pipelined rotation CORDIC and squaring of the cosine and sine terms.
`default_nettype none
module reb_cordic #(
    parameter int CORDIC_STEPS = reb_pkg::CORDIC_STEPS
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_en,
    input  wire logic signed [reb_pkg::ROT_BITS-1:0]  i_rotation,
    output logic [reb_pkg::CC_W-1:0]                  o_cc,
    output logic [reb_pkg::CC_W-1:0]                  o_ss
);

    logic signed [reb_pkg::ANG_W-1:0] r_z [0:CORDIC_STEPS];
    logic signed [reb_pkg::XY_W-1:0]  r_x [0:CORDIC_STEPS];
    logic signed [reb_pkg::XY_W-1:0]  r_y [0:CORDIC_STEPS];
    logic signed [reb_pkg::ANG_W-1:0] w_z;
    logic signed [reb_pkg::ANG_W-1:0] n_z;
    logic signed [reb_pkg::XS_W-1:0]  w_xs;
    logic signed [reb_pkg::XS_W-1:0]  w_ys;
    logic signed [2*reb_pkg::XS_W-1:0] w_xx;
    logic signed [2*reb_pkg::XS_W-1:0] w_yy;
    logic [reb_pkg::CC_W-1:0]         r_cc;
    logic [reb_pkg::CC_W-1:0]         r_ss;

    assign w_z = reb_pkg::ANG_W'(i_rotation) <<< reb_pkg::Q_SHIFT;

    always_comb begin
        priority if (w_z >= reb_pkg::Q30_HALF_PI) begin
            n_z = w_z - reb_pkg::Q30_PI;
        end else if (w_z < -reb_pkg::Q30_HALF_PI) begin
            n_z = w_z + reb_pkg::Q30_PI;
        end else begin
            n_z = w_z;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_z[0] <= n_z;
            r_x[0] <= reb_pkg::Q30_ONE;
            r_y[0] <= '0;
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
        logic signed [reb_pkg::ANG_W-1:0] w_atan;
        assign w_atan = reb_pkg::ANG_W'(reb_pkg::atan_q30(5'(i)));
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_z[i] >= 0) begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - w_atan;
                end else begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + w_atan;
                end
            end
        end
    end

    assign w_xs = reb_pkg::XS_W'(r_x[CORDIC_STEPS] >>> reb_pkg::XS_SHIFT);
    assign w_ys = reb_pkg::XS_W'(r_y[CORDIC_STEPS] >>> reb_pkg::XS_SHIFT);
    assign w_xx = w_xs * w_xs;
    assign w_yy = w_ys * w_ys;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cc <= w_xx[reb_pkg::CC_W-1:0];
            r_ss <= w_yy[reb_pkg::CC_W-1:0];
        end
    end

    assign o_cc = r_cc;
    assign o_ss = r_ss;

endmodule
`default_nettype wire

>>> hw/rtl/reb_div.sv
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none
module reb_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_en,
    input  wire logic [reb_pkg::NUM_W-1:0]     i_num,
    input  wire logic [reb_pkg::DEN_W-1:0]     i_den,
    output logic [reb_pkg::QUOT_W-1:0]         o_quot
);

    localparam int QW = reb_pkg::QUOT_W;

    logic [reb_pkg::NUM_W-1:0] r_rem  [0:QW-1];
    logic [reb_pkg::DEN_W-1:0] r_den  [0:QW-1];
    logic [QW-1:0]             r_quot [0:QW-1];

    for (genvar s = 0; s < QW; s++) begin : g_stage
        localparam int K = QW - 1 - s;
        logic [reb_pkg::NUM_W-1:0] w_rem;
        logic [reb_pkg::DEN_W-1:0] w_den;
        logic [QW-1:0]             w_quot;
        logic [reb_pkg::NUM_W-1:0] w_dsh;
        logic                      w_ge;
        if (s == 0) begin : g_first
            assign w_rem  = i_num;
            assign w_den  = i_den;
            assign w_quot = '0;
        end else begin : g_next
            assign w_rem  = r_rem[s-1];
            assign w_den  = r_den[s-1];
            assign w_quot = r_quot[s-1];
        end
        assign w_dsh = reb_pkg::NUM_W'(w_den) << K;
        assign w_ge  = (w_rem >= w_dsh);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s]  <= w_ge ? (w_rem - w_dsh) : w_rem;
                r_den[s]  <= w_den;
                r_quot[s] <= w_quot | (QW'(w_ge) << K);
            end
        end
    end

    assign o_quot = r_quot[QW-1];

endmodule
`default_nettype wire

>>> hw/rtl/reb_sqrt.sv
// Pipelined integer square root, one root bit per stage.
`default_nettype none
module reb_sqrt (
    input  wire logic                          i_clk,
    input  wire logic                          i_en,
    input  wire logic [reb_pkg::QUOT_W-1:0]    i_rad,
    output logic [reb_pkg::ROOT_W-1:0]         o_root
);

    localparam int RW = reb_pkg::ROOT_W;
    localparam int NW = reb_pkg::QUOT_W;

    logic [NW-1:0] r_rad  [0:RW-1];
    logic [RW-1:0] r_root [0:RW-1];

    for (genvar s = 0; s < RW; s++) begin : g_stage
        localparam int J = RW - 1 - s;
        logic [NW-1:0] w_rad;
        logic [RW-1:0] w_root;
        logic [NW:0]   w_trial;
        logic          w_ge;
        if (s == 0) begin : g_first
            assign w_rad  = i_rad;
            assign w_root = '0;
        end else begin : g_next
            assign w_rad  = r_rad[s-1];
            assign w_root = r_root[s-1];
        end
        assign w_trial = ((NW+1)'(w_root) << (J + 1)) + ((NW+1)'(1) << (2 * J));
        assign w_ge    = ({1'b0, w_rad} >= w_trial);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad[s]  <= w_ge ? NW'({1'b0, w_rad} - w_trial) : w_rad;
                r_root[s] <= w_root | (RW'(w_ge) << J);
            end
        end
    end

    assign o_root = r_root[RW-1];

endmodule
`default_nettype wire

>>> hw/rtl/rotated_ellipse_bounding_box.sv
// Top level: axis-aligned bounding box of a rotated ellipse, fully pipelined.
//
//  Channel  Direction  Handshake                  Payload
//  in       input      i_in_valid / o_in_ready    major, minor, rotation, centre x, centre y
//  out      output     o_out_valid / i_out_ready  box left, top, width, height
//
// One item is accepted per cycle while o_in_ready is high. A box passes through the CORDIC,
// the multiply and sum stages, the divider and the square root, whose last register stage
// feeds the write into the two-entry output queue.
// Reset clears the valid bits of the pipeline and the output queue.
// The pipeline advances whenever its last stage is empty or the queue has room.
`default_nettype none
module rotated_ellipse_bounding_box #(
    parameter int CORDIC_STEPS = reb_pkg::CORDIC_STEPS
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_in_valid,
    output logic                                        o_in_ready,
    input  wire logic [reb_pkg::COORD_BITS-1:0]         i_major_radius,
    input  wire logic [reb_pkg::COORD_BITS-1:0]         i_minor_radius,
    input  wire logic signed [reb_pkg::ROT_BITS-1:0]    i_rotation,
    input  wire logic [reb_pkg::COORD_BITS-1:0]         i_centre_x,
    input  wire logic [reb_pkg::COORD_BITS-1:0]         i_centre_y,
    output logic                                        o_out_valid,
    input  wire logic                                   i_out_ready,
    output logic signed [reb_pkg::OUT_W-1:0]            o_box_left,
    output logic signed [reb_pkg::OUT_W-1:0]            o_box_top,
    output logic [reb_pkg::OUT_W-1:0]                   o_box_width,
    output logic [reb_pkg::OUT_W-1:0]                   o_box_height
);

    localparam int CW  = reb_pkg::COORD_BITS;
    localparam int OW  = reb_pkg::OUT_W;
    localparam int LC  = CORDIC_STEPS + 2;
    localparam int TOT = LC + 2 + reb_pkg::QUOT_W + reb_pkg::ROOT_W;

    logic                        r_vld [0:TOT-1];
    logic [CW-1:0]               r_cx  [0:TOT-1];
    logic [CW-1:0]               r_cy  [0:TOT-1];
    logic [reb_pkg::SQ_W-1:0]    r_a2  [0:LC-1];
    logic [reb_pkg::SQ_W-1:0]    r_b2  [0:LC-1];
    logic                        w_adv;

    logic [reb_pkg::CC_W-1:0]    w_cc;
    logic [reb_pkg::CC_W-1:0]    w_ss;
    logic [reb_pkg::PROD_W-1:0]  r_pwa;
    logic [reb_pkg::PROD_W-1:0]  r_pwb;
    logic [reb_pkg::PROD_W-1:0]  r_pha;
    logic [reb_pkg::PROD_W-1:0]  r_phb;
    logic [reb_pkg::CC_W-1:0]    r_cc;
    logic [reb_pkg::CC_W-1:0]    r_ss;
    logic [reb_pkg::PROD_W:0]    w_sumw;
    logic [reb_pkg::PROD_W:0]    w_sumh;
    logic [reb_pkg::NUM_W-1:0]   r_numw;
    logic [reb_pkg::NUM_W-1:0]   r_numh;
    logic [reb_pkg::DEN_W-1:0]   r_den;
    logic [reb_pkg::QUOT_W-1:0]  w_qw;
    logic [reb_pkg::QUOT_W-1:0]  w_qh;
    logic [reb_pkg::ROOT_W-1:0]  w_rw;
    logic [reb_pkg::ROOT_W-1:0]  w_rh;

    logic signed [OW:0]          w_dl;
    logic signed [OW:0]          w_dt;
    logic signed [OW:0]          w_al;
    logic signed [OW:0]          w_at;
    reb_pkg::t_box               w_box;

    reb_pkg::t_box               r_q [0:1];
    logic [1:0]                  r_cnt;
    logic                        r_rd;
    logic                        w_push;
    logic                        w_pop;
    logic                        w_wr;

    assign w_adv      = !r_vld[TOT-1] || (r_cnt != 2'd2);
    assign o_in_ready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < TOT; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (w_adv) begin
            r_vld[0] <= i_in_valid;
            for (int k = 1; k < TOT; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_cx[0] <= i_centre_x;
            r_cy[0] <= i_centre_y;
            for (int k = 1; k < TOT; k++) begin
                r_cx[k] <= r_cx[k-1];
                r_cy[k] <= r_cy[k-1];
            end
            r_a2[0] <= reb_pkg::SQ_W'(i_major_radius) * reb_pkg::SQ_W'(i_major_radius);
            r_b2[0] <= reb_pkg::SQ_W'(i_minor_radius) * reb_pkg::SQ_W'(i_minor_radius);
            for (int k = 1; k < LC; k++) begin
                r_a2[k] <= r_a2[k-1];
                r_b2[k] <= r_b2[k-1];
            end
        end
    end

    reb_cordic #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_cordic (
        .i_clk      (i_clk),
        .i_en       (w_adv),
        .i_rotation (i_rotation),
        .o_cc       (w_cc),
        .o_ss       (w_ss)
    );

    assign w_sumw = {1'b0, r_pwa} + {1'b0, r_pwb};
    assign w_sumh = {1'b0, r_pha} + {1'b0, r_phb};

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_pwa  <= reb_pkg::PROD_W'(r_a2[LC-1]) * reb_pkg::PROD_W'(w_cc);
            r_pwb  <= reb_pkg::PROD_W'(r_b2[LC-1]) * reb_pkg::PROD_W'(w_ss);
            r_pha  <= reb_pkg::PROD_W'(r_b2[LC-1]) * reb_pkg::PROD_W'(w_cc);
            r_phb  <= reb_pkg::PROD_W'(r_a2[LC-1]) * reb_pkg::PROD_W'(w_ss);
            r_cc   <= w_cc;
            r_ss   <= w_ss;
            r_numw <= {w_sumw, 2'b00};
            r_numh <= {w_sumh, 2'b00};
            r_den  <= {1'b0, r_cc} + {1'b0, r_ss};
        end
    end

    reb_div u_div_w (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_num  (r_numw),
        .i_den  (r_den),
        .o_quot (w_qw)
    );

    reb_div u_div_h (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_num  (r_numh),
        .i_den  (r_den),
        .o_quot (w_qh)
    );

    reb_sqrt u_sqrt_w (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_rad  (w_qw),
        .o_root (w_rw)
    );

    reb_sqrt u_sqrt_h (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_rad  (w_qh),
        .o_root (w_rh)
    );

    assign w_dl = $signed({1'b0, r_cx[TOT-1], 1'b0}) - $signed({1'b0, w_rw});
    assign w_dt = $signed({1'b0, r_cy[TOT-1], 1'b0}) - $signed({1'b0, w_rh});
    assign w_al = w_dl + (OW+1)'(w_dl[OW]);
    assign w_at = w_dt + (OW+1)'(w_dt[OW]);

    always_comb begin
        w_box.left   = w_al[OW:1];
        w_box.top    = w_at[OW:1];
        w_box.width  = w_rw;
        w_box.height = w_rh;
    end

    assign w_push = w_adv && r_vld[TOT-1];
    assign w_pop  = o_out_valid && i_out_ready;
    assign w_wr   = r_rd ^ r_cnt[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_rd  <= 1'b0;
        end else begin
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
            if (w_pop) begin
                r_rd <= !r_rd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[w_wr] <= w_box;
        end
    end

    assign o_out_valid  = (r_cnt != 2'd0);
    assign o_box_left   = r_q[r_rd].left;
    assign o_box_top    = r_q[r_rd].top;
    assign o_box_width  = r_q[r_rd].width;
    assign o_box_height = r_q[r_rd].height;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("output queue count out of range");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[TOT-1] && r_cnt == 2'd2) |-> !o_in_ready)
        else $error("pipeline advanced into a full output queue");

    a_cnt_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ##1 r_cnt == $past(r_cnt + {1'b0, w_push} - {1'b0, w_pop}))
        else $error("output queue count lost an item");

    a_width_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_box_width <= 13'd8190 && o_box_height <= 13'd8190))
        else $error("box size beyond the largest possible value");

endmodule
`default_nettype wire

>>> sim/rotated_ellipse_bounding_box_tb.sv
// Testbench for the rotated ellipse bounding box: random and directed ellipses checked against a predictor.
`timescale 1ns / 1ps
`default_nettype none
module rotated_ellipse_bounding_box_tb;

    typedef struct packed {
        logic [reb_pkg::COORD_BITS-1:0] major;
        logic [reb_pkg::COORD_BITS-1:0] minor;
        logic [reb_pkg::ROT_BITS-1:0]   rot;
        logic [reb_pkg::COORD_BITS-1:0] cx;
        logic [reb_pkg::COORD_BITS-1:0] cy;
    } t_ellipse;

    localparam int STALL_LIMIT = 20000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    logic [reb_pkg::COORD_BITS-1:0] i_major_radius = '0;
    logic [reb_pkg::COORD_BITS-1:0] i_minor_radius = '0;
    logic signed [reb_pkg::ROT_BITS-1:0] i_rotation = '0;
    logic [reb_pkg::COORD_BITS-1:0] i_centre_x = '0;
    logic [reb_pkg::COORD_BITS-1:0] i_centre_y = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    logic signed [reb_pkg::OUT_W-1:0] o_box_left;
    logic signed [reb_pkg::OUT_W-1:0] o_box_top;
    logic [reb_pkg::OUT_W-1:0] o_box_width;
    logic [reb_pkg::OUT_W-1:0] o_box_height;

    t_ellipse pending_ellipses[$];
    reb_pkg::t_box expected_boxes[$];
    int error_count = 0;
    int idle_cycles = 0;
    int hold_off = 0;
    int send_gap = 0;
    bit stimulus_done = 1'b0;
    bit long_stall_done = 1'b0;

    rotated_ellipse_bounding_box i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_major_radius(i_major_radius), .i_minor_radius(i_minor_radius),
        .i_rotation(i_rotation), .i_centre_x(i_centre_x), .i_centre_y(i_centre_y),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_box_left(o_box_left), .o_box_top(o_box_top),
        .o_box_width(o_box_width), .o_box_height(o_box_height)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint floor_sqrt(longint n);
        longint res, bitv;
        res = 0;
        bitv = 64'sd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n = n - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic longint axis_extent(longint p2, longint q2, longint cc, longint ss);
        longint den;
        den = cc + ss;
        if (den == 0) return 0;
        return floor_sqrt((4 * (p2 * cc + q2 * ss)) / den);
    endfunction

    function automatic reb_pkg::t_box predict_box(t_ellipse e);
        longint z, r, x, y, dx, dy, xs, ys, cc, ss, a, b, w, h;
        longint tbl[24];
        reb_pkg::t_box bx;
        tbl = '{843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
                16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
                131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127};
        z = longint'($signed(e.rot)) * (64'sd1 << (30 - reb_pkg::ANGLE_FRAC_BITS));
        r = (z + 64'sd1686629713) % 64'sd3373259426;
        if (r < 0) r = r + 64'sd3373259426;
        z = r - 64'sd1686629713;
        x = 64'sd1 << 30;
        y = 0;
        for (int i = 0; i < reb_pkg::CORDIC_STEPS && i < 24; i++) begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (z >= 0) begin
                x = x - dx; y = y + dy; z = z - tbl[i];
            end else begin
                x = x + dx; y = y - dy; z = z + tbl[i];
            end
        end
        xs = floor_shift(x, 30 - reb_pkg::TRIG_FRAC);
        ys = floor_shift(y, 30 - reb_pkg::TRIG_FRAC);
        cc = xs * xs;
        ss = ys * ys;
        a = longint'(e.major);
        b = longint'(e.minor);
        w = axis_extent(a * a, b * b, cc, ss);
        h = axis_extent(b * b, a * a, cc, ss);
        bx.left = reb_pkg::OUT_W'((2 * longint'(e.cx) - w) / 2);
        bx.top = reb_pkg::OUT_W'((2 * longint'(e.cy) - h) / 2);
        bx.width = reb_pkg::OUT_W'(w);
        bx.height = reb_pkg::OUT_W'(h);
        return bx;
    endfunction

    function automatic int pick_gap();
        if ($urandom_range(0, 99) < 50) return 0;
        if ($urandom_range(0, 99) < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic t_ellipse random_ellipse();
        t_ellipse e;
        e.major = $urandom_range(0, 99) < 20 ? reb_pkg::COORD_BITS'($urandom_range(0, 15))
                                             : reb_pkg::COORD_BITS'($urandom);
        e.minor = $urandom_range(0, 99) < 20 ? reb_pkg::COORD_BITS'($urandom_range(0, 15))
                                             : reb_pkg::COORD_BITS'($urandom);
        if ($urandom_range(0, 99) < 85)
            e.rot = reb_pkg::ROT_BITS'(int'($urandom_range(0, 25736)) - 12868);
        else
            e.rot = reb_pkg::ROT_BITS'($urandom);
        e.cx = reb_pkg::COORD_BITS'($urandom);
        e.cy = reb_pkg::COORD_BITS'($urandom);
        return e;
    endfunction

    initial begin
        int rots[11];
        rots = '{0, 1, -1, 6434, -6434, 12867, 12868, -12868, 16383, -16384, 25736};
        foreach (rots[k])
            pending_ellipses.insert(pending_ellipses.size(),
                t_ellipse'{12'd4095, 12'd1000, reb_pkg::ROT_BITS'(rots[k]),
                           12'd2048, 12'd100});
        pending_ellipses.insert(pending_ellipses.size(),
            t_ellipse'{12'd0, 12'd0, 15'd0, 12'd0, 12'd0});
        pending_ellipses.insert(pending_ellipses.size(),
            t_ellipse'{12'd4095, 12'd4095, 15'd3000, 12'd4095, 12'd4095});
        pending_ellipses.insert(pending_ellipses.size(),
            t_ellipse'{12'd4095, 12'd0, 15'd0, 12'd0, 12'd4095});
        pending_ellipses.insert(pending_ellipses.size(),
            t_ellipse'{12'd0, 12'd4095, 15'd6434, 12'd4095, 12'd0});
        pending_ellipses.insert(pending_ellipses.size(),
            t_ellipse'{12'd4095, 12'd4095, 15'd0, 12'd0, 12'd0});
        pending_ellipses.insert(pending_ellipses.size(),
            t_ellipse'{12'd1, 12'd1, 15'd12868, 12'd1, 12'd1});
        pending_ellipses.insert(pending_ellipses.size(),
            t_ellipse'{12'd2730, 12'd1365, 15'h5555, 12'd2730, 12'd1365});
        for (int n = 0; n < 1000; n++)
            pending_ellipses.insert(pending_ellipses.size(), random_ellipse());
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                expected_boxes.insert(expected_boxes.size(),
                    predict_box({i_major_radius, i_minor_radius,
                                 i_rotation, i_centre_x, i_centre_y}));
            end
            if (!i_in_valid || o_in_ready) begin
                if (send_gap > 0 || pending_ellipses.size() == 0) begin
                    i_in_valid <= 1'b0;
                    if (send_gap > 0) send_gap <= send_gap - 1;
                    if (pending_ellipses.size() == 0) stimulus_done <= 1'b1;
                end else begin
                    t_ellipse e;
                    e = pending_ellipses.pop_front();
                    i_in_valid <= 1'b1;
                    i_major_radius <= e.major;
                    i_minor_radius <= e.minor;
                    i_rotation <= e.rot;
                    i_centre_x <= e.cx;
                    i_centre_y <= e.cy;
                    send_gap <= pick_gap();
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (expected_boxes.size() == 0) begin
                    $error("box with no ellipse pending");
                    error_count = error_count + 1;
                end else begin
                    reb_pkg::t_box eb;
                    eb = expected_boxes.pop_front();
                    if (o_box_left !== eb.left) begin
                        $error("box_left expected %0d got %0d", $signed(eb.left), o_box_left);
                        error_count = error_count + 1;
                    end
                    if (o_box_top !== eb.top) begin
                        $error("box_top expected %0d got %0d", $signed(eb.top), o_box_top);
                        error_count = error_count + 1;
                    end
                    if (o_box_width !== eb.width) begin
                        $error("box_width expected %0d got %0d", eb.width, o_box_width);
                        error_count = error_count + 1;
                    end
                    if (o_box_height !== eb.height) begin
                        $error("box_height expected %0d got %0d", eb.height, o_box_height);
                        error_count = error_count + 1;
                    end
                end
            end
            if (hold_off > 0) begin
                i_out_ready <= 1'b0;
                hold_off <= hold_off - 1;
            end else if (!long_stall_done && pending_ellipses.size() <= 500 &&
                         !stimulus_done) begin
                i_out_ready <= 1'b0;
                hold_off <= 200;
                long_stall_done <= 1'b1;
            end else begin
                int g;
                g = pick_gap();
                i_out_ready <= (g == 0);
                hold_off <= (g > 1) ? g - 1 : 0;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        wait (stimulus_done && !i_in_valid && expected_boxes.size() == 0);
        repeat (100) @(posedge i_clk);
        if (error_count == 0 && expected_boxes.size() == 0 && !o_out_valid)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
`default_nettype wire

>>> filelist.f
hw/rtl/reb_pkg.sv
hw/rtl/reb_cordic.sv
hw/rtl/reb_div.sv
hw/rtl/reb_sqrt.sv
hw/rtl/rotated_ellipse_bounding_box.sv
sim/rotated_ellipse_bounding_box_tb.sv
